/* hw/rtl/i2cmbs_pkg.sv */
// Shared types, constants and helpers for the I2C master byte sequencer.
package i2cmbs_pkg;

    localparam int DELAY_BITS = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SETUP_TICKS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_BIT_TICKS = 2'd1;

    localparam logic [CFG_W-1:0] SETUP_TICKS_RST    = 16'd3;
    localparam logic [CFG_W-1:0] HALF_BIT_TICKS_RST = 16'd5;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [4:0] {
        PH_IDLE        = 5'd0,
        PH_START_A     = 5'd1,
        PH_START_B     = 5'd2,
        PH_START_C     = 5'd3,
        PH_STOP_A      = 5'd4,
        PH_STOP_B      = 5'd5,
        PH_STOP_C      = 5'd6,
        PH_WR_SETUP    = 5'd7,
        PH_WR_HIGH     = 5'd8,
        PH_WR_LOW      = 5'd9,
        PH_WR_ACK      = 5'd10,
        PH_RD_HIGH     = 5'd11,
        PH_RD_LOW      = 5'd12,
        PH_RD_ACKSETUP = 5'd13,
        PH_RD_ACKHIGH  = 5'd14,
        PH_RD_ACKLOW   = 5'd15
    } phase_t;

    // One decoded tick as it travels from front to back
    typedef struct packed {
        logic       cmd_valid;
        cmd_t       cmd;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } tick_t;

    // Queue status seen by the back end
    typedef struct packed {
        logic  not_empty;
        tick_t head;
    } queue_stat_t;

    // Wait reload: saturate to the counter range, zero counts as one tick
    function automatic logic [DELAY_BITS-1:0] wait_load(input logic [CFG_W-1:0] ticks);
        logic [DELAY_BITS-1:0] t;
        if (CFG_W > DELAY_BITS && (ticks >> DELAY_BITS) != '0) begin
            t = '1;
        end else begin
            t = DELAY_BITS'(ticks);
        end
        if (t == '0) begin
            t = DELAY_BITS'(1);
        end
        return t;
    endfunction

endpackage

/* hw/rtl/i2cmbs_front.sv */
// Front end: accepts ticks, decodes the command and queues them for the sequencer.
module i2cmbs_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_command_valid,
    input  logic [1:0]               s_command,
    input  logic [7:0]               s_tx_byte,
    input  logic                     s_send_ack,
    input  logic                     s_sda_in,
    input  logic                     pop,
    output i2cmbs_pkg::queue_stat_t  q_stat
);
    import i2cmbs_pkg::*;

    tick_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                push;
    tick_t               in_tick;

    // Classify the incoming tick
    always_comb begin
        in_tick.cmd_valid = s_command_valid;
        in_tick.cmd       = cmd_t'(s_command);
        in_tick.tx_byte   = s_tx_byte;
        in_tick.send_ack  = s_send_ack;
        in_tick.sda_in    = s_sda_in;
    end

    assign s_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_tick;
        end
    end

    assign q_stat.not_empty = (count_reg != '0);
    assign q_stat.head      = entry_reg[rd_ptr_reg];

endmodule

/* hw/rtl/i2cmbs_back.sv */
// Back end: bus phase sequencer, configuration registers and result register.
module i2cmbs_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [i2cmbs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [i2cmbs_pkg::CFG_W-1:0]        cfg_data,
    input  i2cmbs_pkg::queue_stat_t             q_stat,
    output logic                                pop,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_scl_level,
    output logic                                m_sda_level,
    output logic                                m_busy_res,
    output logic                                m_done_res,
    output logic [7:0]                          m_rx_byte,
    output logic                                m_ack_received
);
    import i2cmbs_pkg::*;

    logic [CFG_W-1:0]      setup_reg;
    logic [CFG_W-1:0]      half_reg;
    phase_t                phase_reg, phase_next;
    logic [3:0]            bit_cnt_reg, bit_cnt_next;
    logic [DELAY_BITS-1:0] wait_reg, wait_next;
    logic [7:0]            shift_reg, shift_next;
    logic [7:0]            rx_reg, rx_next;
    logic                  ack_flag_reg, ack_flag_next;
    logic                  ack_req_reg, ack_req_next;
    logic                  scl_reg, scl_next;
    logic                  sda_reg, sda_next;
    logic                  done_reg, done_next;
    logic                  m_valid_reg, m_valid_next;
    logic [3:0]            bit_inc;
    logic [7:0]            shift_up;
    tick_t                 t;

    assign t        = q_stat.head;
    assign pop      = q_stat.not_empty && (!m_valid_reg || m_ready);
    assign bit_inc  = bit_cnt_reg + 4'd1;
    assign shift_up = {shift_reg[6:0], 1'b0};

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setup_reg <= SETUP_TICKS_RST;
            half_reg  <= HALF_BIT_TICKS_RST;
        end else if (cfg_we) begin
            if (cfg_index == REG_SETUP_TICKS) begin
                setup_reg <= cfg_data;
            end else if (cfg_index == REG_HALF_BIT_TICKS) begin
                half_reg <= cfg_data;
            end
        end
    end

    // One sequencer step per dequeued tick
    always_comb begin
        phase_next    = phase_reg;
        bit_cnt_next  = bit_cnt_reg;
        wait_next     = wait_reg;
        shift_next    = shift_reg;
        rx_next       = rx_reg;
        ack_flag_next = ack_flag_reg;
        ack_req_next  = ack_req_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        done_next     = done_reg;
        if (pop) begin
            done_next = 1'b0;
            if (phase_reg == PH_IDLE) begin
                if (t.cmd_valid) begin
                    bit_cnt_next = '0;
                    case (t.cmd)
                        CMD_START: begin
                            scl_next   = 1'b1;
                            sda_next   = 1'b1;
                            phase_next = PH_START_A;
                            wait_next  = wait_load(half_reg);
                        end
                        CMD_STOP: begin
                            scl_next   = 1'b0;
                            sda_next   = 1'b0;
                            phase_next = PH_STOP_A;
                            wait_next  = wait_load(half_reg);
                        end
                        CMD_WRITE: begin
                            shift_next = t.tx_byte;
                            sda_next   = t.tx_byte[7];
                            phase_next = PH_WR_SETUP;
                            wait_next  = wait_load(setup_reg);
                        end
                        default: begin
                            shift_next   = '0;
                            ack_req_next = t.send_ack;
                            sda_next     = 1'b1;
                            scl_next     = 1'b1;
                            phase_next   = PH_RD_HIGH;
                            wait_next    = wait_load(half_reg);
                        end
                    endcase
                end
            end else if (wait_reg > DELAY_BITS'(1)) begin
                wait_next = wait_reg - DELAY_BITS'(1);
            end else begin
                case (phase_reg)
                    PH_START_A: begin
                        sda_next   = 1'b0;
                        phase_next = PH_START_B;
                        wait_next  = wait_load(half_reg);
                    end
                    PH_START_B: begin
                        scl_next   = 1'b0;
                        phase_next = PH_START_C;
                        wait_next  = wait_load(half_reg);
                    end
                    PH_STOP_A: begin
                        scl_next   = 1'b1;
                        phase_next = PH_STOP_B;
                        wait_next  = wait_load(half_reg);
                    end
                    PH_STOP_B: begin
                        sda_next   = 1'b1;
                        phase_next = PH_STOP_C;
                        wait_next  = wait_load(half_reg);
                    end
                    PH_START_C, PH_STOP_C: begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                    PH_WR_SETUP: begin
                        scl_next   = 1'b1;
                        phase_next = PH_WR_HIGH;
                        wait_next  = wait_load(half_reg);
                    end
                    PH_WR_HIGH: begin
                        scl_next   = 1'b0;
                        phase_next = PH_WR_LOW;
                        wait_next  = wait_load(setup_reg);
                    end
                    PH_WR_LOW: begin
                        shift_next   = shift_up;
                        bit_cnt_next = bit_inc;
                        if (bit_inc < 4'd8) begin
                            sda_next   = shift_up[7];
                            phase_next = PH_WR_SETUP;
                            wait_next  = wait_load(setup_reg);
                        end else begin
                            sda_next   = 1'b1;
                            scl_next   = 1'b1;
                            phase_next = PH_WR_ACK;
                            wait_next  = wait_load(half_reg);
                        end
                    end
                    PH_WR_ACK: begin
                        ack_flag_next = t.sda_in;
                        scl_next      = 1'b0;
                        phase_next    = PH_IDLE;
                        done_next     = 1'b1;
                    end
                    PH_RD_HIGH: begin
                        shift_next = {shift_reg[6:0], t.sda_in};
                        scl_next   = 1'b0;
                        phase_next = PH_RD_LOW;
                        wait_next  = wait_load(half_reg);
                    end
                    PH_RD_LOW: begin
                        bit_cnt_next = bit_inc;
                        if (bit_inc < 4'd8) begin
                            scl_next   = 1'b1;
                            phase_next = PH_RD_HIGH;
                            wait_next  = wait_load(half_reg);
                        end else begin
                            sda_next   = !ack_req_reg;
                            phase_next = PH_RD_ACKSETUP;
                            wait_next  = wait_load(setup_reg);
                        end
                    end
                    PH_RD_ACKSETUP: begin
                        scl_next   = 1'b1;
                        phase_next = PH_RD_ACKHIGH;
                        wait_next  = wait_load(half_reg);
                    end
                    PH_RD_ACKHIGH: begin
                        scl_next   = 1'b0;
                        phase_next = PH_RD_ACKLOW;
                        wait_next  = wait_load(half_reg);
                    end
                    PH_RD_ACKLOW: begin
                        rx_next    = shift_reg;
                        sda_next   = 1'b1;
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Result handshake: hold until taken, reload on each dequeue
    always_comb begin
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            bit_cnt_reg  <= '0;
            wait_reg     <= '0;
            shift_reg    <= '0;
            rx_reg       <= '0;
            ack_flag_reg <= 1'b1;
            ack_req_reg  <= 1'b0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            done_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            bit_cnt_reg  <= bit_cnt_next;
            wait_reg     <= wait_next;
            shift_reg    <= shift_next;
            rx_reg       <= rx_next;
            ack_flag_reg <= ack_flag_next;
            ack_req_reg  <= ack_req_next;
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
            done_reg     <= done_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Result fields are the sequencer state after the last step
    assign m_valid        = m_valid_reg;
    assign m_scl_level    = scl_reg;
    assign m_sda_level    = sda_reg;
    assign m_busy_res     = (phase_reg != PH_IDLE);
    assign m_done_res     = done_reg;
    assign m_rx_byte      = rx_reg;
    assign m_ack_received = ack_flag_reg;

endmodule

/* hw/rtl/i2c_master_byte_sequencer_top.sv */
// Top level of the I2C master byte sequencer.
//
// Every input item is one bus tick: an optional command (start, stop, write
// byte, read byte) plus the sampled SDA level. Every accepted item yields
// exactly one result item: SCL/SDA levels, busy, done pulse, last read byte
// and last write acknowledge. Commands arriving while busy are ignored.
// Configuration: cfg_we/cfg_index/cfg_data write setup_ticks (index 0) and
// half_bit_ticks (index 1); write only while the sequencer is idle.
// Input items go into a two-entry queue; the sequencer takes one item per
// cycle from the queue unless a held result waits on m_ready, and holds
// its result in the output register. An accepted item is written into a
// queue entry; the sequencer step that takes it loads the result register.
// Throughput: one item per cycle while m_ready is high; single sequencer step.
// When m_ready is low the result holds, the queue takes up to two more items
// and s_ready drops; it rises again on the edge that takes the held result.
// Reset empties the queue, clears the result valid, releases SCL and SDA
// and loads the default wait settings (3 and 5).
module i2c_master_byte_sequencer_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [i2cmbs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [i2cmbs_pkg::CFG_W-1:0]        cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_command_valid,
    input  logic [1:0]                          s_command,
    input  logic [7:0]                          s_tx_byte,
    input  logic                                s_send_ack,
    input  logic                                s_sda_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_scl_level,
    output logic                                m_sda_level,
    output logic                                m_busy_res,
    output logic                                m_done_res,
    output logic [7:0]                          m_rx_byte,
    output logic                                m_ack_received
);
    import i2cmbs_pkg::*;

    queue_stat_t q_stat;
    logic        pop;

    // Intake and tick queue
    i2cmbs_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command_valid (s_command_valid),
        .s_command       (s_command),
        .s_tx_byte       (s_tx_byte),
        .s_send_ack      (s_send_ack),
        .s_sda_in        (s_sda_in),
        .pop             (pop),
        .q_stat          (q_stat)
    );

    // Bus sequencer and result register
    i2cmbs_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .q_stat         (q_stat),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_scl_level    (m_scl_level),
        .m_sda_level    (m_sda_level),
        .m_busy_res     (m_busy_res),
        .m_done_res     (m_done_res),
        .m_rx_byte      (m_rx_byte),
        .m_ack_received (m_ack_received)
    );

endmodule

/* hw/rtl/i2cmbs_checker.sv */
// Port-level checks for the I2C master byte sequencer, bound to the top level.
module i2cmbs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_busy_res,
    input logic       m_done_res,
    input logic       m_scl_level,
    input logic       m_sda_level,
    input logic [7:0] m_rx_byte
);

    // A finishing tick never reports busy
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> !m_busy_res)
        else $error("done and busy reported together");

    // No result is shown right after reset and the queue is open
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid && s_ready)
        else $error("result valid or input blocked after reset");

    // A stalled result keeps valid
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its bus levels, read byte and busy flag
    a_hold_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_scl_level) && $stable(m_sda_level)
            && $stable(m_rx_byte) && $stable(m_busy_res))
        else $error("result changed while stalled");

endmodule

bind i2c_master_byte_sequencer_top i2cmbs_checker u_i2cmbs_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_busy_res  (m_busy_res),
    .m_done_res  (m_done_res),
    .m_scl_level (m_scl_level),
    .m_sda_level (m_sda_level),
    .m_rx_byte   (m_rx_byte)
);

/* dv/tb.sv */
// Self-checking testbench for the I2C master byte sequencer top level.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cmbs_pkg::*;

    // Register indexes past the end of the register list, writes are dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
    localparam int TOTAL_TICKS = 1850;

    // Bus levels and status returned for every tick
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       ack;
    } bus_levels_t;

    typedef enum {SDA_LOW, SDA_HIGH, SDA_RANDOM} sda_drive_t;

    // One row of the directed script: command tick, noise flag, known levels
    typedef struct {
        tick_t       item;
        logic        noisy;
        logic        typed;
        bus_levels_t levels;
    } script_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_command_valid;
    logic [1:0]           s_command;
    logic [7:0]           s_tx_byte;
    logic                 s_send_ack;
    logic                 s_sda_in;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_scl_level;
    logic                 m_sda_level;
    logic                 m_busy_res;
    logic                 m_done_res;
    logic [7:0]           m_rx_byte;
    logic                 m_ack_received;

    i2c_master_byte_sequencer_top uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command_valid(s_command_valid),
        .s_command      (s_command),
        .s_tx_byte      (s_tx_byte),
        .s_send_ack     (s_send_ack),
        .s_sda_in       (s_sda_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_scl_level    (m_scl_level),
        .m_sda_level    (m_sda_level),
        .m_busy_res     (m_busy_res),
        .m_done_res     (m_done_res),
        .m_rx_byte      (m_rx_byte),
        .m_ack_received (m_ack_received)
    );

    // Sequencer mirror
    phase_t      p_phase;
    logic [3:0]  p_bits;
    logic [15:0] p_wait;
    logic [7:0]  p_shift;
    logic [7:0]  p_rx;
    logic        p_ack;
    logic        p_ack_req;
    logic        p_scl;
    logic        p_sda;
    logic [15:0] cfg_setup;
    logic [15:0] cfg_half;

    bus_levels_t pending_levels[$];

    bit          idle_on;
    int unsigned hold_cycles;
    int unsigned mismatches;
    int unsigned ticks_sent;
    int unsigned results_checked;
    int unsigned settings_used;
    int unsigned cmd_count[4];

    // Directed script: typed levels are the first tick of each command.
    // Walked once on reset settings and once on zero waits; the bus ends
    // in the same state both times, so the typed levels hold for both.
    script_row_t script[13] = '{
        '{'{1'b0, CMD_START, 8'h00, 1'b0, 1'b0}, 1'b0, 1'b1,
          '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1}},
        '{'{1'b1, CMD_START, 8'h00, 1'b0, 1'b0}, 1'b0, 1'b1,
          '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1}},
        '{'{1'b1, CMD_WRITE, 8'hFF, 1'b0, 1'b0}, 1'b0, 1'b1,
          '{1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1}},
        '{'{1'b1, CMD_WRITE, 8'h00, 1'b0, 1'b1}, 1'b0, 1'b1,
          '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
        '{'{1'b1, CMD_WRITE, 8'hA5, 1'b1, 1'b0}, 1'b0, 1'b0, '0},
        '{'{1'b1, CMD_READ,  8'h00, 1'b1, 1'b1}, 1'b0, 1'b1,
          '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
        '{'{1'b1, CMD_READ,  8'h3C, 1'b0, 1'b0}, 1'b1, 1'b1,
          '{1'b1, 1'b1, 1'b1, 1'b0, 8'hFF, 1'b0}},
        '{'{1'b1, CMD_STOP,  8'h00, 1'b0, 1'b0}, 1'b0, 1'b1,
          '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
        '{'{1'b1, CMD_STOP,  8'h00, 1'b0, 1'b1}, 1'b0, 1'b0, '0},
        '{'{1'b1, CMD_START, 8'h00, 1'b1, 1'b0}, 1'b1, 1'b0, '0},
        '{'{1'b1, CMD_READ,  8'h00, 1'b1, 1'b0}, 1'b0, 1'b0, '0},
        '{'{1'b1, CMD_WRITE, 8'h5A, 1'b0, 1'b1}, 1'b0, 1'b0, '0},
        '{'{1'b1, CMD_STOP,  8'h00, 1'b0, 1'b0}, 1'b0, 1'b0, '0}
    };

    // Zero means one tick; 16-bit settings always fit the wait counter
    function automatic logic [15:0] wait_ticks(input logic [15:0] setting);
        return (setting == '0) ? 16'd1 : setting;
    endfunction

    function automatic void arm(input phase_t ph, input logic [15:0] setting);
        p_phase = ph;
        p_wait  = wait_ticks(setting);
    endfunction

    // Advance the mirror by one tick and return the levels it shows
    function automatic bus_levels_t predict_tick(input tick_t t);
        bus_levels_t lv;
        logic        fin;
        fin = 1'b0;
        if (p_phase == PH_IDLE) begin
            if (t.cmd_valid) begin
                p_bits = '0;
                case (t.cmd)
                    CMD_START: begin
                        p_scl = 1'b1;
                        p_sda = 1'b1;
                        arm(PH_START_A, cfg_half);
                    end
                    CMD_STOP: begin
                        p_sda = 1'b0;
                        p_scl = 1'b0;
                        arm(PH_STOP_A, cfg_half);
                    end
                    CMD_WRITE: begin
                        p_shift = t.tx_byte;
                        p_sda   = t.tx_byte[7];
                        arm(PH_WR_SETUP, cfg_setup);
                    end
                    default: begin
                        p_shift   = '0;
                        p_ack_req = t.send_ack;
                        p_sda     = 1'b1;
                        p_scl     = 1'b1;
                        arm(PH_RD_HIGH, cfg_half);
                    end
                endcase
            end
        end else if (p_wait > 16'd1) begin
            p_wait = p_wait - 16'd1;
        end else begin
            case (p_phase)
                PH_START_A: begin
                    p_sda = 1'b0;
                    arm(PH_START_B, cfg_half);
                end
                PH_START_B: begin
                    p_scl = 1'b0;
                    arm(PH_START_C, cfg_half);
                end
                PH_STOP_A: begin
                    p_scl = 1'b1;
                    arm(PH_STOP_B, cfg_half);
                end
                PH_STOP_B: begin
                    p_sda = 1'b1;
                    arm(PH_STOP_C, cfg_half);
                end
                PH_START_C, PH_STOP_C: begin
                    p_phase = PH_IDLE;
                    fin     = 1'b1;
                end
                PH_WR_SETUP: begin
                    p_scl = 1'b1;
                    arm(PH_WR_HIGH, cfg_half);
                end
                PH_WR_HIGH: begin
                    p_scl = 1'b0;
                    arm(PH_WR_LOW, cfg_setup);
                end
                PH_WR_LOW: begin
                    p_shift = p_shift << 1;
                    p_bits  = p_bits + 4'd1;
                    if (p_bits < 4'd8) begin
                        p_sda = p_shift[7];
                        arm(PH_WR_SETUP, cfg_setup);
                    end else begin
                        p_sda = 1'b1;
                        p_scl = 1'b1;
                        arm(PH_WR_ACK, cfg_half);
                    end
                end
                PH_WR_ACK: begin
                    p_ack   = t.sda_in;
                    p_scl   = 1'b0;
                    p_phase = PH_IDLE;
                    fin     = 1'b1;
                end
                PH_RD_HIGH: begin
                    p_shift = {p_shift[6:0], t.sda_in};
                    p_scl   = 1'b0;
                    arm(PH_RD_LOW, cfg_half);
                end
                PH_RD_LOW: begin
                    p_bits = p_bits + 4'd1;
                    if (p_bits < 4'd8) begin
                        p_scl = 1'b1;
                        arm(PH_RD_HIGH, cfg_half);
                    end else begin
                        p_sda = ~p_ack_req;
                        arm(PH_RD_ACKSETUP, cfg_setup);
                    end
                end
                PH_RD_ACKSETUP: begin
                    p_scl = 1'b1;
                    arm(PH_RD_ACKHIGH, cfg_half);
                end
                PH_RD_ACKHIGH: begin
                    p_scl = 1'b0;
                    arm(PH_RD_ACKLOW, cfg_half);
                end
                PH_RD_ACKLOW: begin
                    p_rx    = p_shift;
                    p_sda   = 1'b1;
                    p_phase = PH_IDLE;
                    fin     = 1'b1;
                end
                default: p_phase = PH_IDLE;
            endcase
        end
        lv.scl  = p_scl;
        lv.sda  = p_sda;
        lv.busy = (p_phase != PH_IDLE);
        lv.done = fin;
        lv.rx   = p_rx;
        lv.ack  = p_ack;
        return lv;
    endfunction

    function automatic int unsigned draw_gap();
        return idle_on ? $urandom_range(0, 19) : 0;
    endfunction

    // Wait settings lean small so commands stay short
    function automatic logic [15:0] pick_wait();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 16'($urandom_range(0, 3));
        if (r < 95) return 16'($urandom_range(4, 8));
        return 16'($urandom_range(9, 20));
    endfunction

    // Clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Offer one tick, wait for it to be taken, queue its expected levels
    task automatic send_tick(input tick_t item, input logic typed,
                             input bus_levels_t levels);
        int unsigned gap;
        bus_levels_t lv;
        gap = draw_gap();
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_command_valid <= item.cmd_valid;
        s_command       <= item.cmd;
        s_tx_byte       <= item.tx_byte;
        s_send_ack      <= item.send_ack;
        s_sda_in        <= item.sda_in;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        lv = predict_tick(item);
        pending_levels.push_back(typed ? levels : lv);
        ticks_sent++;
    endtask

    // Issue one command tick, then bus ticks until the sequencer is idle
    task automatic run_command(input tick_t item, input sda_drive_t drive,
                               input int unsigned noise_pct, input logic typed,
                               input bus_levels_t levels);
        tick_t t;
        if (item.cmd_valid && p_phase == PH_IDLE) cmd_count[item.cmd]++;
        send_tick(item, typed, levels);
        while (p_phase != PH_IDLE) begin
            t.cmd_valid = ($urandom_range(0, 99) < noise_pct);
            t.cmd       = cmd_t'($urandom_range(0, 3));
            t.tx_byte   = 8'($urandom);
            t.send_ack  = 1'($urandom);
            case (drive)
                SDA_LOW:  t.sda_in = 1'b0;
                SDA_HIGH: t.sda_in = 1'b1;
                default:  t.sda_in = 1'($urandom);
            endcase
            send_tick(t, 1'b0, '0);
        end
    endtask

    // Bring the sequencer idle, drop valid, let every result drain
    task automatic quiesce();
        tick_t t;
        while (p_phase != PH_IDLE) begin
            t         = '0;
            t.sda_in  = 1'($urandom);
            send_tick(t, 1'b0, '0);
        end
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_SETUP_TICKS) cfg_setup = val;
        else if (idx == REG_HALF_BIT_TICKS) cfg_half = val;
        settings_used++;
    endtask

    // Mostly a full transfer with random bytes; otherwise commands in any order
    task automatic run_sequence();
        tick_t t;
        int unsigned n;
        bit well_formed;
        well_formed = ($urandom_range(0, 9) < 8);
        n = $urandom_range(1, 4);
        if (well_formed) begin
            t = '0;
            t.cmd_valid = 1'b1;
            t.cmd = CMD_START;
            run_command(t, SDA_RANDOM, 10, 1'b0, '0);
        end
        repeat (n) begin
            t.cmd_valid = 1'b1;
            t.cmd       = well_formed ? (($urandom_range(0, 1) != 0) ? CMD_WRITE : CMD_READ)
                                      : cmd_t'($urandom_range(0, 3));
            t.tx_byte   = 8'($urandom);
            t.send_ack  = 1'($urandom);
            t.sda_in    = 1'($urandom);
            run_command(t, SDA_RANDOM, 10, 1'b0, '0);
            // Occasional plain ticks between commands
            repeat ($urandom_range(0, 3)) begin
                t.cmd_valid = 1'b0;
                t.sda_in    = 1'($urandom);
                send_tick(t, 1'b0, '0);
            end
        end
        if (well_formed) begin
            t = '0;
            t.cmd_valid = 1'b1;
            t.cmd = CMD_STOP;
            run_command(t, SDA_RANDOM, 10, 1'b0, '0);
        end
    endtask

    // Result side: random stall per item, long hold on request
    initial begin
        int unsigned stall;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_cycles != 0) begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end else begin
                stall = draw_gap();
            end
            @(negedge aclk);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Compare each delivered item against the oldest expectation
    always @(posedge aclk) begin
        bus_levels_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_levels.size() == 0) begin
                $error("result item with no expectation pending");
                mismatches++;
            end else begin
                want = pending_levels.pop_front();
                check_field("scl_level", want.scl, m_scl_level);
                check_field("sda_level", want.sda, m_sda_level);
                check_field("busy_res", want.busy, m_busy_res);
                check_field("done_res", want.done, m_done_res);
                check_field("rx_byte", want.rx, m_rx_byte);
                check_field("ack_received", want.ack, m_ack_received);
                results_checked++;
            end
        end
    end

    // Run limit
    initial begin
        #40_000_000;
        $display("[i2c_master_byte_sequencer_top] ERROR");
        $finish;
    end

    // Main sequence
    initial begin
        int unsigned random_start;
        int unsigned phase_no;
        tick_t t;

        aresetn         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        s_valid         = 1'b0;
        s_command_valid = 1'b0;
        s_command       = '0;
        s_tx_byte       = '0;
        s_send_ack      = 1'b0;
        s_sda_in        = 1'b0;
        idle_on         = 1'b1;
        hold_cycles     = 0;
        mismatches      = 0;
        ticks_sent      = 0;
        results_checked = 0;
        settings_used   = 0;
        cmd_count       = '{default: 0};

        p_phase   = PH_IDLE;
        p_bits    = '0;
        p_wait    = '0;
        p_shift   = '0;
        p_rx      = '0;
        p_ack     = 1'b1;
        p_ack_req = 1'b0;
        p_scl     = 1'b1;
        p_sda     = 1'b1;
        cfg_setup = SETUP_TICKS_RST;
        cfg_half  = HALF_BIT_TICKS_RST;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed script on reset settings
        foreach (script[i])
            run_command(script[i].item, script[i].item.sda_in ? SDA_HIGH : SDA_LOW,
                        script[i].noisy ? 30 : 0, script[i].typed, script[i].levels);
        quiesce();

        // Zero waits count as one tick; spare indexes must change nothing
        set_reg(REG_SETUP_TICKS, 16'd0);
        set_reg(REG_HALF_BIT_TICKS, 16'd0);
        set_reg(REG_SPARE_LO, 16'hFFFF);
        set_reg(REG_SPARE_HI, 16'h0007);
        idle_on = 1'b0;
        foreach (script[i])
            run_command(script[i].item, script[i].item.sda_in ? SDA_HIGH : SDA_LOW,
                        script[i].noisy ? 30 : 0, script[i].typed, script[i].levels);
        quiesce();

        // Long waits: a stop on a long half bit, a read on a long setup
        set_reg(REG_HALF_BIT_TICKS, 16'd40);
        set_reg(REG_SETUP_TICKS, 16'd1);
        t = '0;
        t.cmd_valid = 1'b1;
        t.cmd = CMD_STOP;
        run_command(t, SDA_RANDOM, 0, 1'b0, '0);
        quiesce();
        set_reg(REG_SETUP_TICKS, 16'd60);
        set_reg(REG_HALF_BIT_TICKS, 16'd1);
        t.cmd = CMD_READ;
        t.send_ack = 1'b1;
        run_command(t, SDA_RANDOM, 0, 1'b0, '0);
        quiesce();

        // Random transfers over changing wait settings
        random_start = ticks_sent;
        phase_no = 0;
        while (ticks_sent < TOTAL_TICKS) begin
            set_reg(REG_SETUP_TICKS, pick_wait());
            set_reg(REG_HALF_BIT_TICKS, pick_wait());
            if ($urandom_range(0, 3) == 0)
                set_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE_LO,
                        16'($urandom));
            idle_on = ($urandom_range(0, 3) != 0);
            // Long output stall while ticks keep coming, to back up the input
            if (phase_no == 0) begin
                idle_on     = 1'b0;
                hold_cycles = 200;
            end
            repeat ($urandom_range(1, 3))
                if (ticks_sent < TOTAL_TICKS) run_sequence();
            quiesce();
            phase_no++;
        end

        repeat (10) @(posedge aclk);
        $display("Sent %0d bus ticks (%0d random): %0d start, %0d stop, %0d write, %0d read",
                 ticks_sent, ticks_sent - random_start, cmd_count[CMD_START],
                 cmd_count[CMD_STOP], cmd_count[CMD_WRITE], cmd_count[CMD_READ]);
        $display("%0d register writes incl. zero and long waits, %0d results compared",
                 settings_used, results_checked);
        if (mismatches == 0 && pending_levels.size() == 0) begin
            $display("[i2c_master_byte_sequencer_top] OK");
        end else begin
            $display("[i2c_master_byte_sequencer_top] ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/i2cmbs_pkg.sv
hw/rtl/i2cmbs_front.sv
hw/rtl/i2cmbs_back.sv
hw/rtl/i2c_master_byte_sequencer_top.sv
hw/rtl/i2cmbs_checker.sv
dv/tb.sv
